/* design/chip8_pkg.sv */
// ----------------------------------------------------------------------------
// chip8_pkg
// Shared types, codes and constants of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package chip8_pkg;

    localparam int unsigned FONT_BYTES = 80;
    localparam logic [11:0] PC_RESET   = 12'h200;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_EXEC = 2'd1;
    localparam logic [1:0] KIND_ROW  = 2'd2;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // instruction classes that steer the controller
    typedef enum logic [3:0] {
        OP_NOP, OP_CLS, OP_RET, OP_WRX, OP_WRF, OP_DRW, OP_BCD, OP_STORE, OP_LOAD
    } t_op;

    typedef enum logic [4:0] {
        CMD_IDLE, CMD_CLR, CMD_LOADB, CMD_ROWRD, CMD_FETCH_HI, CMD_FETCH_LO,
        CMD_GET_OP, CMD_GET_VX, CMD_GET_VY, CMD_GET_V0, CMD_EXEC, CMD_CLS,
        CMD_FLAG, CMD_DRAW_RD, CMD_DRAW_WR, CMD_DRAW_VF, CMD_BCD, CMD_STR_RD,
        CMD_STR_WR, CMD_LD_RD, CMD_LD_WR, CMD_FIN, CMD_OUT
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code code;
        logic      take;
    } t_ctl;

    typedef struct packed {
        t_op  op;
        logic clr_last;
        logic cls_last;
        logic drw_last;
        logic bcd_last;
        logic xfr_last;
        logic n_zero;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (a < 7'(FONT_BYTES)) begin
            b = FONT[a];
        end
        return b;
    endfunction

    function automatic t_op op_class(input logic [15:0] w);
        t_op c;
        c = OP_NOP;
        case (w[15:12])
            4'h0: begin
                if (w == 16'h00E0) c = OP_CLS;
                else if (w == 16'h00EE) c = OP_RET;
            end
            4'h6, 4'h7, 4'hC: c = OP_WRX;
            4'h8: begin
                case (w[3:0]) inside
                    [4'h0:4'h3]:                c = OP_WRX;
                    4'h4, 4'h5, 4'h6, 4'h7, 4'hE: c = OP_WRF;
                    default:                    c = OP_NOP;
                endcase
            end
            4'hD: c = OP_DRW;
            4'hF: begin
                case (w[7:0])
                    8'h07, 8'h0A: c = OP_WRX;
                    8'h1E:        c = OP_WRF;
                    8'h33:        c = OP_BCD;
                    8'h55:        c = OP_STORE;
                    8'h65:        c = OP_LOAD;
                    default:      c = OP_NOP;
                endcase
            end
            default: c = OP_NOP;
        endcase
        return c;
    endfunction

endpackage

/* design/chip8_ctrl.sv */
// ----------------------------------------------------------------------------
// chip8_ctrl
// Sequencer of the CHIP-8 core: steps each transaction through the datapath.
// ----------------------------------------------------------------------------
module chip8_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    output logic              o_stall,
    input  chip8_pkg::t_sts   i_sts,
    output chip8_pkg::t_ctl   o_ctl
);

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_LDB, ST_RD, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6,
        ST_EX, ST_CLS, ST_FLAG, ST_DRD, ST_DWR, ST_DVF, ST_BCD, ST_SRD, ST_SWR,
        ST_LRD, ST_LWR, ST_FIN, ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   take;

    assign take    = (r_state == ST_IDLE) && i_valid;
    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:  if (i_sts.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (take) begin
                    case (i_kind)
                        chip8_pkg::KIND_LOAD: n_state = ST_LDB;
                        chip8_pkg::KIND_EXEC: n_state = ST_F1;
                        chip8_pkg::KIND_ROW:  n_state = ST_RD;
                        default:              n_state = ST_FIN;
                    endcase
                end
            end
            ST_LDB, ST_RD: n_state = ST_FIN;
            ST_F1: n_state = ST_F2;
            ST_F2: n_state = ST_F3;
            ST_F3: n_state = ST_F4;
            ST_F4: n_state = ST_F5;
            ST_F5: n_state = ST_F6;
            ST_F6: n_state = ST_EX;
            ST_EX: begin
                case (i_sts.op)
                    chip8_pkg::OP_CLS:   n_state = ST_CLS;
                    chip8_pkg::OP_WRF:   n_state = ST_FLAG;
                    chip8_pkg::OP_DRW:   n_state = i_sts.n_zero ? ST_DVF : ST_DRD;
                    chip8_pkg::OP_BCD:   n_state = ST_BCD;
                    chip8_pkg::OP_STORE: n_state = ST_SRD;
                    chip8_pkg::OP_LOAD:  n_state = ST_LRD;
                    default:             n_state = ST_FIN;
                endcase
            end
            ST_CLS:  if (i_sts.cls_last) n_state = ST_FIN;
            ST_FLAG: n_state = ST_FIN;
            ST_DRD:  n_state = ST_DWR;
            ST_DWR:  n_state = i_sts.drw_last ? ST_DVF : ST_DRD;
            ST_DVF:  n_state = ST_FIN;
            ST_BCD:  if (i_sts.bcd_last) n_state = ST_FIN;
            ST_SRD:  n_state = ST_SWR;
            ST_SWR:  n_state = i_sts.xfr_last ? ST_FIN : ST_SRD;
            ST_LRD:  n_state = ST_LWR;
            ST_LWR:  n_state = i_sts.xfr_last ? ST_FIN : ST_LRD;
            ST_FIN:  n_state = ST_OUT;
            ST_OUT:  if (i_sts.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctl.take = take;
        case (r_state)
            ST_CLR:  o_ctl.code = chip8_pkg::CMD_CLR;
            ST_LDB:  o_ctl.code = chip8_pkg::CMD_LOADB;
            ST_RD:   o_ctl.code = chip8_pkg::CMD_ROWRD;
            ST_F1:   o_ctl.code = chip8_pkg::CMD_FETCH_HI;
            ST_F2:   o_ctl.code = chip8_pkg::CMD_FETCH_LO;
            ST_F3:   o_ctl.code = chip8_pkg::CMD_GET_OP;
            ST_F4:   o_ctl.code = chip8_pkg::CMD_GET_VX;
            ST_F5:   o_ctl.code = chip8_pkg::CMD_GET_VY;
            ST_F6:   o_ctl.code = chip8_pkg::CMD_GET_V0;
            ST_EX:   o_ctl.code = chip8_pkg::CMD_EXEC;
            ST_CLS:  o_ctl.code = chip8_pkg::CMD_CLS;
            ST_FLAG: o_ctl.code = chip8_pkg::CMD_FLAG;
            ST_DRD:  o_ctl.code = chip8_pkg::CMD_DRAW_RD;
            ST_DWR:  o_ctl.code = chip8_pkg::CMD_DRAW_WR;
            ST_DVF:  o_ctl.code = chip8_pkg::CMD_DRAW_VF;
            ST_BCD:  o_ctl.code = chip8_pkg::CMD_BCD;
            ST_SRD:  o_ctl.code = chip8_pkg::CMD_STR_RD;
            ST_SWR:  o_ctl.code = chip8_pkg::CMD_STR_WR;
            ST_LRD:  o_ctl.code = chip8_pkg::CMD_LD_RD;
            ST_LWR:  o_ctl.code = chip8_pkg::CMD_LD_WR;
            ST_FIN:  o_ctl.code = chip8_pkg::CMD_FIN;
            ST_OUT:  o_ctl.code = i_sts.out_free ? chip8_pkg::CMD_OUT : chip8_pkg::CMD_IDLE;
            default: o_ctl.code = chip8_pkg::CMD_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_exec_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_kind == chip8_pkg::KIND_EXEC) |=> r_state == ST_F1)
        else $error("execute transaction did not start fetch");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !i_sts.out_free) |=> r_state == ST_OUT)
        else $error("result dropped while output register busy");
    a_clr_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR && i_sts.clr_last) |=> r_state == ST_IDLE)
        else $error("memory clear pass did not end");
`endif

endmodule

/* design/chip8_dp.sv */
// ----------------------------------------------------------------------------
// chip8_dp
// Datapath of the CHIP-8 core: memory, registers, frame buffer, result.
// ----------------------------------------------------------------------------
module chip8_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chip8_pkg::t_ctl   i_ctl,
    output chip8_pkg::t_sts   o_sts,
    input  logic [1:0]        i_kind,
    input  logic [11:0]       i_addr,
    input  logic [7:0]        i_data,
    input  logic [15:0]       i_keys_down,
    input  logic [7:0]        i_rand_byte,
    input  logic [4:0]        i_row_select,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [11:0]       o_pc_now,
    output logic [15:0]       o_opcode_done,
    output logic              o_draw_pulse,
    output logic              o_sound_pulse,
    output logic              o_key_wait,
    output logic [63:0]       o_row_pixels
);

    logic [7:0]  r_mem [4096];
    logic [7:0]  r_mem_q;
    logic [7:0]  r_regs [16];
    logic [15:0] r_reg_vld;
    logic [7:0]  r_reg_q;
    logic        r_reg_qv;
    logic [11:0] r_stack [16];
    logic [63:0] r_rows [32];

    logic [1:0]  r_kind;
    logic [11:0] r_addr;
    logic [7:0]  r_data;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd;
    logic [4:0]  r_row;
    logic [15:0] r_op;
    logic [7:0]  r_vx, r_vy, r_v0;
    logic [11:0] r_i, r_pc;
    logic [3:0]  r_sp;
    logic [7:0]  r_dt, r_st;
    logic [11:0] r_cnt;
    logic        r_flag, r_hit, r_drew, r_wait, r_snd;
    logic [63:0] r_rowpix;

    logic [11:0] mem_raddr, mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_we;
    logic [3:0]  reg_raddr, reg_waddr;
    logic [7:0]  reg_wdata, reg_val;
    logic        reg_we;
    logic [4:0]  fr_addr;
    logic [63:0] fr_row, spr_mask;
    logic [127:0] spr_dbl;

    logic [3:0]  op_x, op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn, pc2, pc4, sub_i;
    logic        ex_we, ex_flag, ex_wait;
    logic [7:0]  ex_wdata;
    logic [11:0] ex_next;
    logic [3:0]  key_idx;
    logic [8:0]  sum9;
    logic [12:0] isum;
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t, bcd_o;
    logic [7:0]  bcd_dig;
    logic        out_free;
    chip8_pkg::t_cmd_code code;

    assign code    = i_ctl.code;
    assign op_x    = r_op[11:8];
    assign op_n    = r_op[3:0];
    assign op_kk   = r_op[7:0];
    assign op_nnn  = r_op[11:0];
    assign pc2     = r_pc + 12'd2;
    assign pc4     = r_pc + 12'd4;
    assign sub_i   = r_i + {8'd0, r_cnt[3:0]};
    assign reg_val = r_reg_qv ? r_reg_q : 8'd0;
    assign out_free = !o_valid || !i_stall;

    assign o_sts.op       = chip8_pkg::op_class(r_op);
    assign o_sts.clr_last = &r_cnt;
    assign o_sts.cls_last = &r_cnt[4:0];
    assign o_sts.drw_last = (r_cnt[3:0] == (op_n - 4'd1));
    assign o_sts.bcd_last = (r_cnt[1:0] == 2'd2);
    assign o_sts.xfr_last = (r_cnt[3:0] == op_x);
    assign o_sts.n_zero   = (op_n == 4'd0);
    assign o_sts.out_free = out_free;

    // decimal digits of Vx; tens by reciprocal multiply (x * 205 >> 11)
    always_comb begin
        bcd_h    = (r_vx >= 8'd200) ? 2'd2 : ((r_vx >= 8'd100) ? 2'd1 : 2'd0);
        bcd_rem  = 7'(r_vx - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0)));
        bcd_prod = 15'({8'd0, bcd_rem} * 15'd205);
        bcd_t    = bcd_prod[14:11];
        bcd_o    = 4'(bcd_rem - 7'({3'd0, bcd_t} * 7'd10));
        case (r_cnt[1:0])
            2'd0:    bcd_dig = {6'd0, bcd_h};
            2'd1:    bcd_dig = {4'd0, bcd_t};
            default: bcd_dig = {4'd0, bcd_o};
        endcase
    end

    // highest pressed key wins
    always_comb begin
        key_idx = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (r_keys[k]) key_idx = 4'(k);
        end
    end

    always_comb begin
        mem_raddr = r_pc;
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = chip8_pkg::font_byte(r_cnt[6:0]);
        case (code)
            chip8_pkg::CMD_FETCH_LO: mem_raddr = r_pc + 12'd1;
            chip8_pkg::CMD_DRAW_RD,
            chip8_pkg::CMD_LD_RD:    mem_raddr = sub_i;
            chip8_pkg::CMD_CLR: begin
                // font only in the first 128-byte block, zero above it
                mem_we = 1'b1;
                if (r_cnt[11:7] != 5'd0) mem_wdata = 8'd0;
            end
            chip8_pkg::CMD_LOADB: begin
                mem_we = 1'b1; mem_waddr = r_addr; mem_wdata = r_data;
            end
            chip8_pkg::CMD_BCD: begin
                mem_we = 1'b1; mem_waddr = r_i + {10'd0, r_cnt[1:0]}; mem_wdata = bcd_dig;
            end
            chip8_pkg::CMD_STR_WR: begin
                mem_we = 1'b1; mem_waddr = sub_i; mem_wdata = reg_val;
            end
            default: ;
        endcase
    end

    // instruction effects on PC and the data registers
    always_comb begin
        ex_next  = pc2;
        ex_we    = 1'b0;
        ex_wdata = 8'd0;
        ex_flag  = 1'b0;
        ex_wait  = 1'b0;
        sum9     = {1'b0, r_vx} + {1'b0, r_vy};
        isum     = {1'b0, r_i} + {5'd0, r_vx};
        case (r_op[15:12])
            4'h0: if (r_op == 16'h00EE) ex_next = r_stack[r_sp - 4'd1] + 12'd2;
            4'h1, 4'h2: ex_next = op_nnn;
            4'h3: if (r_vx == op_kk) ex_next = pc4;
            4'h4: if (r_vx != op_kk) ex_next = pc4;
            4'h5: if (op_n == 4'd0 && r_vx == r_vy) ex_next = pc4;
            4'h6: begin ex_we = 1'b1; ex_wdata = op_kk; end
            4'h7: begin ex_we = 1'b1; ex_wdata = r_vx + op_kk; end
            4'h8: begin
                ex_we = 1'b1;
                case (op_n)
                    4'h0: ex_wdata = r_vy;
                    4'h1: ex_wdata = r_vx | r_vy;
                    4'h2: ex_wdata = r_vx & r_vy;
                    4'h3: ex_wdata = r_vx ^ r_vy;
                    4'h4: begin ex_wdata = sum9[7:0]; ex_flag = sum9[8]; end
                    4'h5: begin ex_wdata = r_vx - r_vy; ex_flag = r_vx > r_vy; end
                    4'h6: begin ex_wdata = {1'b0, r_vx[7:1]}; ex_flag = r_vx[0]; end
                    4'h7: begin ex_wdata = r_vy - r_vx; ex_flag = r_vy > r_vx; end
                    4'hE: begin ex_wdata = {r_vx[6:0], 1'b0}; ex_flag = r_vx[7]; end
                    default: ex_we = 1'b0;
                endcase
            end
            4'h9: if (op_n == 4'd0 && r_vx != r_vy) ex_next = pc4;
            4'hB: ex_next = op_nnn + {4'd0, r_v0};
            4'hC: begin ex_we = 1'b1; ex_wdata = r_rnd & op_kk; end
            4'hE: begin
                if (op_kk == 8'h9E && r_vx[7:4] == 4'd0 && r_keys[r_vx[3:0]]) ex_next = pc4;
                if (op_kk == 8'hA1 && !(r_vx[7:4] == 4'd0 && r_keys[r_vx[3:0]]))
                    ex_next = pc4;
            end
            4'hF: begin
                case (op_kk)
                    8'h07: begin ex_we = 1'b1; ex_wdata = r_dt; end
                    8'h0A: begin
                        if (r_keys == 16'd0) begin
                            ex_wait = 1'b1; ex_next = r_pc;
                        end else begin
                            ex_we = 1'b1; ex_wdata = {4'd0, key_idx};
                        end
                    end
                    8'h1E: ex_flag = isum[12];
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        reg_raddr = r_cnt[3:0];
        case (code)
            chip8_pkg::CMD_GET_OP: reg_raddr = op_x;
            chip8_pkg::CMD_GET_VX: reg_raddr = r_op[7:4];
            chip8_pkg::CMD_GET_VY: reg_raddr = 4'd0;
            default: ;
        endcase
        reg_we    = 1'b0;
        reg_waddr = 4'hF;
        reg_wdata = {7'd0, r_flag};
        case (code)
            chip8_pkg::CMD_EXEC: begin
                reg_we = ex_we; reg_waddr = op_x; reg_wdata = ex_wdata;
            end
            chip8_pkg::CMD_FLAG:    reg_we = 1'b1;
            chip8_pkg::CMD_DRAW_VF: begin reg_we = 1'b1; reg_wdata = {7'd0, r_hit}; end
            chip8_pkg::CMD_LD_WR: begin
                reg_we = 1'b1; reg_waddr = r_cnt[3:0]; reg_wdata = r_mem_q;
            end
            default: ;
        endcase
    end

    // frame buffer row port and sprite placement
    always_comb begin
        case (code)
            chip8_pkg::CMD_CLS:     fr_addr = r_cnt[4:0];
            chip8_pkg::CMD_DRAW_WR: fr_addr = r_vy[4:0] + r_cnt[4:0];
            default:                fr_addr = r_row;
        endcase
        fr_row   = r_rows[fr_addr];
        spr_dbl  = {r_mem_q, 56'd0, r_mem_q, 56'd0} >> r_vx[5:0];
        spr_mask = spr_dbl[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_mem_q <= r_mem[mem_raddr];
        if (reg_we) r_regs[reg_waddr] <= reg_wdata;
        r_reg_q <= r_regs[reg_raddr];
    end

    always_ff @(posedge i_clk) begin
        case (code)
            chip8_pkg::CMD_FETCH_LO: r_op[15:8] <= r_mem_q;
            chip8_pkg::CMD_GET_OP:   r_op[7:0]  <= r_mem_q;
            chip8_pkg::CMD_GET_VX:   r_vx <= reg_val;
            chip8_pkg::CMD_GET_VY:   r_vy <= reg_val;
            chip8_pkg::CMD_GET_V0:   r_v0 <= reg_val;
            default: ;
        endcase
        if (i_ctl.take) begin
            r_kind <= i_kind;
            r_addr <= i_addr;
            r_data <= i_data;
            r_keys <= i_keys_down;
            r_rnd  <= i_rand_byte;
            r_row  <= i_row_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= 16'd0;
            r_reg_qv  <= 1'b0;
            r_i       <= 12'd0;
            r_pc      <= chip8_pkg::PC_RESET;
            r_sp      <= 4'd0;
            r_dt      <= 8'd0;
            r_st      <= 8'd0;
            r_cnt     <= 12'd0;
            r_flag    <= 1'b0;
            r_hit     <= 1'b0;
            r_drew    <= 1'b0;
            r_wait    <= 1'b0;
            r_snd     <= 1'b0;
            r_rowpix  <= 64'd0;
            o_valid   <= 1'b0;
            for (int k = 0; k < 16; k++) r_stack[k] <= 12'd0;
            for (int k = 0; k < 32; k++) r_rows[k] <= 64'd0;
        end else begin
            r_reg_qv <= r_reg_vld[reg_raddr];
            if (reg_we) r_reg_vld[reg_waddr] <= 1'b1;
            if (i_ctl.take) begin
                r_drew   <= 1'b0;
                r_wait   <= 1'b0;
                r_snd    <= 1'b0;
                r_rowpix <= 64'd0;
            end
            if (!i_stall && code != chip8_pkg::CMD_OUT) o_valid <= 1'b0;
            case (code)
                chip8_pkg::CMD_CLR:    r_cnt <= r_cnt + 12'd1;
                chip8_pkg::CMD_ROWRD:  r_rowpix <= fr_row;
                chip8_pkg::CMD_GET_V0: r_cnt <= 12'd0;
                chip8_pkg::CMD_EXEC: begin
                    r_pc   <= ex_next;
                    r_flag <= ex_flag;
                    r_wait <= ex_wait;
                    r_hit  <= 1'b0;
                    if (r_op == 16'h00EE) r_sp <= r_sp - 4'd1;
                    case (r_op[15:12])
                        4'h2: begin
                            r_stack[r_sp] <= r_pc;
                            r_sp <= r_sp + 4'd1;
                        end
                        4'hA: r_i <= op_nnn;
                        4'hF: begin
                            case (op_kk)
                                8'h15: r_dt <= r_vx;
                                8'h18: r_st <= r_vx;
                                8'h1E: r_i <= isum[11:0];
                                8'h29: r_i <= {2'd0, r_vx, 2'd0} + {4'd0, r_vx};
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                chip8_pkg::CMD_CLS: begin
                    if (fr_row != 64'd0) r_drew <= 1'b1;
                    r_rows[fr_addr] <= 64'd0;
                    r_cnt <= r_cnt + 12'd1;
                end
                chip8_pkg::CMD_DRAW_WR: begin
                    if ((fr_row & spr_mask) != 64'd0) r_hit <= 1'b1;
                    if (spr_mask != 64'd0) r_drew <= 1'b1;
                    r_rows[fr_addr] <= fr_row ^ spr_mask;
                    r_cnt <= r_cnt + 12'd1;
                end
                chip8_pkg::CMD_BCD,
                chip8_pkg::CMD_STR_WR,
                chip8_pkg::CMD_LD_WR: r_cnt <= r_cnt + 12'd1;
                chip8_pkg::CMD_FIN: begin
                    if (r_kind == chip8_pkg::KIND_EXEC) begin
                        if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                        if (r_st != 8'd0) r_st <= r_st - 8'd1;
                        r_snd <= (r_st == 8'd1);
                    end
                end
                chip8_pkg::CMD_OUT: begin
                    o_valid       <= 1'b1;
                    o_pc_now      <= r_pc;
                    o_opcode_done <= (r_kind == chip8_pkg::KIND_EXEC) ? r_op : 16'd0;
                    o_draw_pulse  <= r_drew;
                    o_sound_pulse <= r_snd;
                    o_key_wait    <= r_wait;
                    o_row_pixels  <= r_rowpix;
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/chip8_instruction_core.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 processor: 4 KiB memory, V0..VF, I, PC, stack, timers, 64x32 display.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one transaction per item. i_kind selects
// a memory byte load, one instruction step (keys and random byte supplied)
// or a display row read. Output channel (o_valid / i_stall): one result per
// input transaction, held in an output register until the receiver takes it.
// A load or row read passes through its own step, finish and result. A plain
// instruction fetches both opcode bytes and reads Vx, Vy and V0 through the
// one-port memory and register file, takes a turnaround step, then execute,
// finish and result. A flag write, a screen clear, a draw (read and write per
// sprite row, then VF), BCD and Fx55/Fx65 (read and write per register) add
// their own steps before finish. A new transaction is taken in the cycle
// after the result is loaded; the slowest items are a screen clear or
// Fx55/Fx65 over all sixteen registers. One item is in flight.
// Reset: after i_rst_n the 4096-byte memory is swept one byte per cycle to
// load the font and zero the rest; o_stall stays high throughout the sweep.
// Stall: a finished result waits in the output register while i_stall is
// high; the core holds o_stall while a newer result waits for that register.
// ----------------------------------------------------------------------------
module chip8_instruction_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_addr,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_keys_down,
    input  logic [7:0]  i_rand_byte,
    input  logic [4:0]  i_row_select,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_pc_now,
    output logic [15:0] o_opcode_done,
    output logic        o_draw_pulse,
    output logic        o_sound_pulse,
    output logic        o_key_wait,
    output logic [63:0] o_row_pixels
);

    chip8_pkg::t_ctl ctl;   // sequencer commands
    chip8_pkg::t_sts sts;   // datapath status back to the sequencer

    // sequence each transaction; an instruction runs fetch, operand reads, execute, result
    chip8_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // hold all architectural state and the output register
    chip8_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_addr        (i_addr),
        .i_data        (i_data),
        .i_keys_down   (i_keys_down),
        .i_rand_byte   (i_rand_byte),
        .i_row_select  (i_row_select),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pc_now      (o_pc_now),
        .o_opcode_done (o_opcode_done),
        .o_draw_pulse  (o_draw_pulse),
        .o_sound_pulse (o_sound_pulse),
        .o_key_wait    (o_key_wait),
        .o_row_pixels  (o_row_pixels)
    );

endmodule

/* sim/chip8_instruction_core_check.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_core_check
// Watches both channels of the CHIP-8 core, predicts each result from its own
// copy of the machine state and compares every field of every result.
// ----------------------------------------------------------------------------
module chip8_instruction_core_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_addr,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_keys_down,
    input  logic [7:0]  i_rand_byte,
    input  logic [4:0]  i_row_select,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [11:0] i_pc_now,
    input  logic [15:0] i_opcode_done,
    input  logic        i_draw_pulse,
    input  logic        i_sound_pulse,
    input  logic        i_key_wait,
    input  logic [63:0] i_row_pixels,
    output int          o_fail_count,
    output int          o_pending,
    output logic [11:0] o_pc_model
);

    typedef struct packed {
        logic [11:0] pc_now;
        logic [15:0] opcode;
        logic        draw;
        logic        sound;
        logic        key_wait;
        logic [63:0] row;
    } t_outcome;

    logic [7:0]  mem_img [4096];
    logic [7:0]  vreg [16];
    logic [11:0] index_r;
    logic [11:0] pc_r;
    logic [11:0] call_stack [16];
    logic [3:0]  sp_r;
    logic [7:0]  delay_r;
    logic [7:0]  sound_r;
    logic [63:0] frame [32];

    t_outcome outcome_q[$];
    int       fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = outcome_q.size();
    assign o_pc_model   = pc_r;

    task automatic clear_machine();
        for (int i = 0; i < 4096; i++)
            mem_img[i] = (i < chip8_pkg::FONT_BYTES) ? chip8_pkg::FONT[i] : 8'h00;
        for (int i = 0; i < 16; i++) begin
            vreg[i]       = 8'h00;
            call_stack[i] = 12'h000;
        end
        for (int i = 0; i < 32; i++) frame[i] = 64'h0;
        index_r = 12'h000;
        pc_r    = chip8_pkg::PC_RESET;
        sp_r    = 4'h0;
        delay_r = 8'h00;
        sound_r = 8'h00;
    endtask

    // one instruction step; fills opcode, draw, sound and key_wait
    task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                   inout t_outcome res);
        logic [15:0] w;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy, b;
        logic [11:0] nnn, nxt;
        logic [8:0]  sum9;
        logic [12:0] sum13;
        logic [63:0] m;
        logic [4:0]  r;
        logic [6:0]  s;
        logic        hit, drew, waiting, f;
        w   = {mem_img[pc_r], mem_img[pc_r + 12'd1]};
        x   = w[11:8];
        y   = w[7:4];
        n   = w[3:0];
        kk  = w[7:0];
        nnn = w[11:0];
        vx  = vreg[x];
        vy  = vreg[y];
        nxt = pc_r + 12'd2;
        drew = 1'b0;
        waiting = 1'b0;
        case (w[15:12])
            4'h0: begin
                if (w == 16'h00E0) begin
                    for (int i = 0; i < 32; i++) begin
                        if (frame[i] != 64'h0) drew = 1'b1;
                        frame[i] = 64'h0;
                    end
                end else if (w == 16'h00EE) begin
                    sp_r = sp_r - 4'd1;
                    nxt  = call_stack[sp_r] + 12'd2;
                end
            end
            4'h1: nxt = nnn;
            4'h2: begin
                call_stack[sp_r] = pc_r;
                sp_r = sp_r + 4'd1;
                nxt  = nnn;
            end
            4'h3: if (vx == kk) nxt = pc_r + 12'd4;
            4'h4: if (vx != kk) nxt = pc_r + 12'd4;
            4'h5: if (n == 4'h0 && vx == vy) nxt = pc_r + 12'd4;
            4'h6: vreg[x] = kk;
            4'h7: vreg[x] = vx + kk;
            4'h8: begin
                case (n)
                    4'h0: vreg[x] = vy;
                    4'h1: vreg[x] = vx | vy;
                    4'h2: vreg[x] = vx & vy;
                    4'h3: vreg[x] = vx ^ vy;
                    4'h4: begin
                        sum9 = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum9[7:0];
                        vreg[15] = {7'd0, sum9[8]};
                    end
                    4'h5: begin
                        f = vx > vy;
                        vreg[x] = vx - vy;
                        vreg[15] = {7'd0, f};
                    end
                    4'h6: begin
                        vreg[x] = vx >> 1;
                        vreg[15] = {7'd0, vx[0]};
                    end
                    4'h7: begin
                        f = vy > vx;
                        vreg[x] = vy - vx;
                        vreg[15] = {7'd0, f};
                    end
                    4'hE: begin
                        vreg[x] = vx << 1;
                        vreg[15] = {7'd0, vx[7]};
                    end
                    default: ;
                endcase
            end
            4'h9: if (n == 4'h0 && vx != vy) nxt = pc_r + 12'd4;
            4'hA: index_r = nnn;
            4'hB: nxt = nnn + {4'h0, vreg[0]};
            4'hC: vreg[x] = rnd & kk;
            4'hD: begin
                hit = 1'b0;
                s   = {1'b0, vx[5:0]};
                for (int i = 0; i < n; i++) begin
                    b = mem_img[index_r + 12'(i)];
                    m = ({b, 56'h0} >> s) | ({b, 56'h0} << (7'd64 - s));
                    r = vy[4:0] + 5'(i);
                    if ((frame[r] & m) != 64'h0) hit = 1'b1;
                    if (m != 64'h0) drew = 1'b1;
                    frame[r] = frame[r] ^ m;
                end
                vreg[15] = {7'd0, hit};
            end
            4'hE: begin
                // register values above 15 name no key
                if (kk == 8'h9E) begin
                    if (vx < 8'd16 && keys[vx[3:0]]) nxt = pc_r + 12'd4;
                end else if (kk == 8'hA1) begin
                    if (!(vx < 8'd16 && keys[vx[3:0]])) nxt = pc_r + 12'd4;
                end
            end
            default: begin
                case (kk)
                    8'h07: vreg[x] = delay_r;
                    8'h0A: begin
                        if (keys == 16'h0) begin
                            waiting = 1'b1;
                            nxt = pc_r;
                        end else begin
                            for (int i = 0; i < 16; i++) if (keys[i]) vreg[x] = 8'(i);
                        end
                    end
                    8'h15: delay_r = vx;
                    8'h18: sound_r = vx;
                    8'h1E: begin
                        sum13 = {1'b0, index_r} + {5'd0, vx};
                        index_r = sum13[11:0];
                        vreg[15] = {7'd0, sum13[12]};
                    end
                    8'h29: index_r = 12'(vx * 12'd5);
                    8'h33: begin
                        mem_img[index_r]         = vx / 8'd100;
                        mem_img[index_r + 12'd1] = (vx / 8'd10) % 8'd10;
                        mem_img[index_r + 12'd2] = vx % 8'd10;
                    end
                    8'h55: for (int i = 0; i <= x; i++) mem_img[index_r + 12'(i)] = vreg[i];
                    8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem_img[index_r + 12'(i)];
                    default: ;
                endcase
            end
        endcase
        pc_r = nxt;
        if (delay_r != 8'h00) delay_r = delay_r - 8'd1;
        if (sound_r != 8'h00) begin
            if (sound_r == 8'h01) res.sound = 1'b1;
            sound_r = sound_r - 8'd1;
        end
        res.opcode   = w;
        res.draw     = drew;
        res.key_wait = waiting;
    endtask

    initial begin
        fail_count = 0;
        clear_machine();
    end

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            clear_machine();
            outcome_q.delete();
        end else begin
            // predict on every accepted input transaction
            if (i_valid && !i_in_stall) begin
                want = '0;
                case (i_kind)
                    chip8_pkg::KIND_LOAD: mem_img[i_addr] = i_data;
                    chip8_pkg::KIND_EXEC: run_instruction(i_keys_down, i_rand_byte, want);
                    chip8_pkg::KIND_ROW:  want.row = frame[i_row_select];
                    default: ;
                endcase
                want.pc_now = pc_r;
                outcome_q.push_back(want);
            end
            // compare on every accepted result transaction
            if (i_out_valid && !i_out_stall) begin
                got = '{i_pc_now, i_opcode_done, i_draw_pulse, i_sound_pulse,
                        i_key_wait, i_row_pixels};
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, got);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* sim/chip8_instruction_core_test.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_core_test
// Drives the CHIP-8 core with short instruction bursts written into memory at
// the current program counter, plus row reads and noise; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module chip8_instruction_core_test;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [11:0] i_addr;
    logic [7:0]  i_data;
    logic [15:0] i_keys_down;
    logic [7:0]  i_rand_byte;
    logic [4:0]  i_row_select;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_pc_now;
    logic [15:0] o_opcode_done;
    logic        o_draw_pulse;
    logic        o_sound_pulse;
    logic        o_key_wait;
    logic [63:0] o_row_pixels;

    int          fail_count;
    int          pending;
    logic [11:0] pc_model;
    int          cycles = 0;
    int          sent_total;
    int          sent_exec;
    int          stall_left = 0;
    logic        calm;      // suppress receiver stalls and sender gaps during a stretch

    chip8_instruction_core u_dut (.*);

    chip8_instruction_core_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_stall   (o_stall),
        .i_kind       (i_kind),
        .i_addr       (i_addr),
        .i_data       (i_data),
        .i_keys_down  (i_keys_down),
        .i_rand_byte  (i_rand_byte),
        .i_row_select (i_row_select),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_pc_now     (o_pc_now),
        .i_opcode_done(o_opcode_done),
        .i_draw_pulse (o_draw_pulse),
        .i_sound_pulse(o_sound_pulse),
        .i_key_wait   (o_key_wait),
        .i_row_pixels (o_row_pixels),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pc_model   (pc_model)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver stall: mostly free, short bursts, now and then a long one.
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n || calm) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                i_stall <= 1'b0;
            end else if (r < 96) begin
                stall_left <= $urandom_range(0, 2);
                i_stall    <= 1'b1;
            end else begin
                stall_left <= $urandom_range(10, 40);
                i_stall    <= 1'b1;
            end
        end
    end

    // Watchdog: budget covers the reset sweep, slow draws, long gaps and stalls.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Idle the sender for a random stretch; mostly none or short.
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = (calm || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one transaction and hold it until the core accepts it.
    task automatic push_item(input logic [1:0] kind, input logic [11:0] addr,
                             input logic [7:0] data, input logic [15:0] keys,
                             input logic [7:0] rnd, input logic [4:0] row);
        sender_gap();
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_addr       <= addr;
        i_data       <= data;
        i_keys_down  <= keys;
        i_rand_byte  <= rnd;
        i_row_select <= row;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_total++;
        if (kind == chip8_pkg::KIND_EXEC) sent_exec++;
    endtask

    // Drop valid and hold off until every outstanding result is back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_keys();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 16'h0000;
        if (r < 5) return 16'(1) << $urandom_range(0, 15);
        return 16'($urandom);
    endfunction

    // Random instruction word, weighted toward register setup and valid forms.
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        logic [7:0]  f_codes [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29,
                                     8'h33, 8'h55, 8'h65};
        int          r;
        w = 16'($urandom);
        r = $urandom_range(0, 19);
        case (r)
            0:       w = ($urandom_range(0, 2) == 0) ? 16'h00EE :
                         ($urandom_range(0, 1) == 0) ? 16'h00E0 : {4'h0, w[11:0]};
            1, 2:    w[15:12] = 4'h6;
            3:       w[15:12] = 4'h7;
            4, 5:    begin
                w[15:12] = 4'h8;
                if ($urandom_range(0, 4) != 0) w[3:0] = 4'($urandom_range(0, 7));
                if ($urandom_range(0, 5) == 0) w[3:0] = 4'hE;
            end
            6, 7:    begin
                w[15:12] = 4'hD;
                if ($urandom_range(0, 3) != 0) w[3:0] = 4'($urandom_range(0, 5));
            end
            8:       w[15:12] = 4'hA;
            9, 10:   begin
                w[15:12] = 4'hF;
                w[7:0]   = f_codes[$urandom_range(0, 8)];
            end
            11:      begin
                w[15:12] = 4'hE;
                w[7:0]   = ($urandom_range(0, 1) == 0) ? 8'h9E : 8'hA1;
            end
            12:      begin
                w[15:12] = ($urandom_range(0, 1) == 0) ? 4'h5 : 4'h9;
                if ($urandom_range(0, 3) != 0) w[3:0] = 4'h0;
            end
            13:      w[15:12] = 4'h3 + 4'($urandom_range(0, 1));
            14:      w[15:12] = 4'hC;
            15:      w[15:12] = 4'h1 + 4'($urandom_range(0, 1));
            16:      w[15:12] = 4'hB;
            default: ;
        endcase
        return w;
    endfunction

    // Write one burst of instructions at the current PC and run them in turn.
    task automatic run_burst(input logic [15:0] words [$], input logic [15:0] keys);
        logic [11:0] at;
        drain();
        at = pc_model;
        foreach (words[i]) begin
            push_item(chip8_pkg::KIND_LOAD, at, words[i][15:8], 16'($urandom),
                      8'($urandom), 5'($urandom));
            push_item(chip8_pkg::KIND_LOAD, at + 12'd1, words[i][7:0], 16'($urandom),
                      8'($urandom), 5'($urandom));
            at = at + 12'd2;
        end
        foreach (words[i]) push_item(chip8_pkg::KIND_EXEC, 12'($urandom), 8'($urandom), keys,
                                     8'($urandom), 5'($urandom));
    endtask

    initial begin
        logic [15:0] prog [$];
        int          r;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = chip8_pkg::KIND_LOAD;
        i_addr       = '0;
        i_data       = '0;
        i_keys_down  = '0;
        i_rand_byte  = '0;
        i_row_select = '0;
        calm         = 1'b0;
        sent_total   = 0;
        sent_exec    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: flags with VF as target, font sprite, collision, clear,
        // BCD, store/load, call/return, skips, wait for key, timers, wraps.
        prog = '{16'h60FF, 16'h6101, 16'h8F14, 16'h8014, 16'h8F15, 16'h8F17,
                 16'h8F0E, 16'h8F06, 16'h6A3F, 16'h6B1F, 16'hFA29, 16'hDAB5};
        run_burst(prog, 16'hFFFF);
        prog = '{16'hDAB5, 16'hDAB0, 16'h00E0, 16'h00E0, 16'h62FF, 16'hF233,
                 16'hF255, 16'hF265, 16'h9120, 16'hF20A};
        run_burst(prog, 16'h0000);
        run_burst('{16'hF20A}, 16'h8001);
        run_burst('{16'h6302, 16'hF318, 16'hF315, 16'hF307, 16'hAFFF, 16'hF21E,
                   16'hE39E, 16'hE3A1}, 16'h0008);
        run_burst('{16'h2FFE}, 16'h0000);
        run_burst('{16'h00EE, 16'h00EE}, 16'h0000);
        run_burst('{16'hBFFF, 16'h1FFE}, 16'h0000);
        push_item(chip8_pkg::KIND_ROW, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31);
        push_item(2'd3, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0);
        push_item(chip8_pkg::KIND_LOAD, 12'hFFF, 8'hFF, 16'h0000, 8'h00, 5'd0);

        // Random: mostly instruction bursts with random content, the rest
        // row reads, stray loads, bare executes and unknown kinds.
        while (sent_total < 800) begin
            calm = (sent_total > 400 && sent_total < 480);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                prog.delete();
                repeat ($urandom_range(1, 4)) prog.push_back(pick_word());
                run_burst(prog, pick_keys());
            end else if (r == 7) begin
                push_item(chip8_pkg::KIND_ROW, 12'($urandom), 8'($urandom), pick_keys(),
                          8'($urandom), 5'($urandom));
            end else if (r == 8) begin
                push_item(($urandom_range(0, 1) == 0) ? chip8_pkg::KIND_LOAD : 2'd3,
                          12'($urandom), 8'($urandom), pick_keys(), 8'($urandom),
                          5'($urandom));
            end else begin
                push_item(chip8_pkg::KIND_EXEC, 12'($urandom), 8'($urandom), pick_keys(),
                          8'($urandom), 5'($urandom));
            end
        end
        calm = 1'b0;

        drain();
        repeat (60) @(posedge i_clk);
        $display("Sent %0d transactions, %0d of them instruction steps, in short bursts",
                 sent_total, sent_exec);
        $display("with row reads, stray loads and unknown kinds under random gaps and stalls.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
